// ----- hw/rtl/cdc_pkg.sv -----
package cdc_pkg;

    localparam logic [7:0] DELAY_TICKS = 8'd60;
    localparam logic [8:0] LAST_CYLINDER = 9'd202;
    localparam logic [8:0] WORDS_PER_SECTOR = 9'd256;

    localparam logic [1:0] KIND_READ = 2'd0;
    localparam logic [1:0] KIND_WRITE = 2'd1;
    localparam logic [1:0] KIND_TICK = 2'd2;

    localparam logic [2:0] REG_STATUS = 3'd0;
    localparam logic [2:0] REG_ERROR = 3'd1;
    localparam logic [2:0] REG_CONTROL = 3'd2;
    localparam logic [2:0] REG_WORD_COUNT = 3'd3;
    localparam logic [2:0] REG_BUS_ADDR = 3'd4;
    localparam logic [2:0] REG_DISK_ADDR = 3'd5;

    localparam logic [2:0] FN_CTRL_RESET = 3'd0;
    localparam logic [2:0] FN_WRITE = 3'd1;
    localparam logic [2:0] FN_READ = 3'd2;
    localparam logic [2:0] FN_READ_CHECK = 3'd3;
    localparam logic [2:0] FN_SEEK = 3'd4;
    localparam logic [2:0] FN_DRIVE_RESET = 3'd6;

    localparam logic [15:0] STATUS_RESET = 16'o4700;
    localparam logic [15:0] CONTROL_RESET = 16'o200;
    localparam logic [15:0] CONTROL_RO_MASK = 16'hf080;
    localparam logic [3:0] LAST_SECTOR = 4'o13;

    typedef enum logic [1:0] {
        OP_READ,
        OP_WRITE,
        OP_TICK,
        OP_IGNORE
    } op_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [2:0] register_index;
        logic [15:0] write_data;
    } item_t;

    typedef struct packed {
        logic [15:0] read_data;
        logic bus_error;
        logic irq;
        logic xfer_valid;
        logic xfer_to_disk;
        logic [12:0] xfer_block;
        logic [17:0] xfer_address;
        logic [8:0] xfer_words;
    } result_t;

    typedef struct packed {
        op_t op;
        logic [2:0] index;
        logic [15:0] data;
    } cmd_t;

endpackage

// ----- hw/rtl/cartridge_disk_controller_unit.sv -----
// Every accepted transaction yields exactly one result, in order.
// A transaction is registered in the intake queue, then processed and its result registered in the result queue.
// Throughput is one transaction per cycle while the result queue has room or is being popped.
// Two-entry queues sit between the intake, the register file and the result ports.
// Reset is asynchronous and active low; it restores the controller registers and queue pointers, not queue entries.
module cartridge_disk_controller_unit (
    input logic clk,
    input logic rst_n,
    input logic push,
    output logic full,
    input cdc_pkg::item_t item,
    output logic empty,
    input logic pop,
    output cdc_pkg::result_t result
);
    import cdc_pkg::*;

    cmd_t cmd;
    logic cmd_empty;
    logic cmd_take;

    cdc_front u_front (
        .clk(clk),
        .rst_n(rst_n),
        .push(push),
        .full(full),
        .item(item),
        .cmd_empty(cmd_empty),
        .cmd_take(cmd_take),
        .cmd(cmd)
    );

    cdc_back u_back (
        .clk(clk),
        .rst_n(rst_n),
        .cmd_empty(cmd_empty),
        .cmd_take(cmd_take),
        .cmd(cmd),
        .empty(empty),
        .pop(pop),
        .result(result)
    );

endmodule

// ----- hw/rtl/cdc_front.sv -----
module cdc_front (
    input logic clk,
    input logic rst_n,
    input logic push,
    output logic full,
    input cdc_pkg::item_t item,
    output logic cmd_empty,
    input logic cmd_take,
    output cdc_pkg::cmd_t cmd
);
    import cdc_pkg::*;

    cmd_t entry_reg [2];
    logic wr_ptr_reg;
    logic wr_ptr_next;
    logic rd_ptr_reg;
    logic rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic enq;
    logic deq;
    cmd_t classified;

    always_comb
    begin
        classified.index = item.register_index;
        classified.data = item.write_data;
        case (item.kind)
            KIND_READ: classified.op = OP_READ;
            KIND_WRITE: classified.op = OP_WRITE;
            KIND_TICK: classified.op = OP_TICK;
            default: classified.op = OP_IGNORE;
        endcase
    end

    assign full = (count_reg == 2'd2);
    assign cmd_empty = (count_reg == 2'd0);
    assign enq = push && !full;
    assign deq = cmd_take && !cmd_empty;
    assign cmd = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = enq ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = deq ? !rd_ptr_reg : rd_ptr_reg;
        count_next = count_reg + {1'b0, enq} - {1'b0, deq};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (enq)
        begin
            entry_reg[wr_ptr_reg] <= classified;
        end
    end

endmodule

// ----- hw/rtl/cdc_back.sv -----
module cdc_back (
    input logic clk,
    input logic rst_n,
    input logic cmd_empty,
    output logic cmd_take,
    input cdc_pkg::cmd_t cmd,
    output logic empty,
    input logic pop,
    output cdc_pkg::result_t result
);
    import cdc_pkg::*;

    logic [15:0] status_reg, status_next;
    logic [15:0] error_reg, error_next;
    logic [15:0] control_reg, control_next;
    logic [15:0] wcount_reg, wcount_next;
    logic [15:0] baddr_reg, baddr_next;
    logic [15:0] daddr_reg, daddr_next;
    logic [2:0] drive_reg, drive_next;
    logic [7:0] cyl_reg, cyl_next;
    logic surface_reg, surface_next;
    logic [3:0] sector_reg, sector_next;
    logic [7:0] delay_reg, delay_next;

    result_t entry_reg [2];
    logic wr_ptr_reg;
    logic rd_ptr_reg;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic res_pop;
    result_t res;

    logic [15:0] place;
    logic [15:0] room;
    logic [8:0] words;
    logic [16:0] sum;
    logic [3:0] sector_inc;
    logic [8:0] cyl_inc;
    logic [12:0] block;

    assign res_pop = pop && !empty;
    assign empty = (count_reg == 2'd0);
    assign cmd_take = !cmd_empty && ((count_reg != 2'd2) || pop);
    assign result = entry_reg[rd_ptr_reg];

    always_comb
    begin
        place = {drive_reg & 3'd0, cyl_reg, surface_reg, sector_reg};
        room = ~wcount_reg + 16'd1;
        words = (room < {7'd0, WORDS_PER_SECTOR}) ? room[8:0] : WORDS_PER_SECTOR;
        sum = {1'b0, baddr_reg} + {7'd0, words, 1'b0};
        sector_inc = sector_reg + 4'd1;
        cyl_inc = {1'b0, cyl_reg} + 9'd1;
        block = {1'b0, cyl_reg, 4'd0} + {2'b0, cyl_reg, 3'd0}
            + (surface_reg ? 13'd12 : 13'd0) + {9'd0, sector_reg};
    end

    always_comb
    begin
        status_next = status_reg;
        error_next = error_reg;
        control_next = control_reg;
        wcount_next = wcount_reg;
        baddr_next = baddr_reg;
        daddr_next = daddr_reg;
        drive_next = drive_reg;
        cyl_next = cyl_reg;
        surface_next = surface_reg;
        sector_next = sector_reg;
        delay_next = delay_reg;
        res = '0;
        case (cmd.op)
            OP_READ:
            begin
                case (cmd.index)
                    REG_STATUS: res.read_data = status_reg;
                    REG_ERROR: res.read_data = error_reg;
                    REG_CONTROL: res.read_data = control_reg & 16'hfffe;
                    REG_WORD_COUNT: res.read_data = wcount_reg;
                    REG_BUS_ADDR: res.read_data = baddr_reg;
                    REG_DISK_ADDR: res.read_data = daddr_reg;
                    default: res.bus_error = 1'b1;
                endcase
            end
            OP_WRITE:
            begin
                case (cmd.index)
                    REG_CONTROL: control_next = (cmd.data & ~CONTROL_RO_MASK)
                        | (control_reg & CONTROL_RO_MASK);
                    REG_WORD_COUNT: wcount_next = cmd.data;
                    REG_BUS_ADDR: baddr_next = cmd.data;
                    REG_DISK_ADDR:
                    begin
                        daddr_next = cmd.data;
                        drive_next = cmd.data[15:13];
                        cyl_next = cmd.data[12:5];
                        surface_next = cmd.data[4];
                        sector_next = cmd.data[3:0];
                    end
                    default: ;
                endcase
            end
            OP_TICK:
            begin
                if (control_reg[0])
                begin
                    control_next[13] = 1'b0;
                    case (control_reg[3:1])
                        FN_CTRL_RESET:
                        begin
                            status_next = STATUS_RESET;
                            error_next = '0;
                            control_next = CONTROL_RESET;
                            wcount_next = '0;
                            baddr_next = '0;
                            daddr_next = '0;
                            delay_next = '0;
                            drive_next = '0;
                            cyl_next = '0;
                            surface_next = 1'b0;
                            sector_next = '0;
                        end
                        FN_WRITE, FN_READ, FN_READ_CHECK:
                        begin
                            status_next[6] = 1'b0;
                            control_next[7] = 1'b0;
                            daddr_next = place;
                            if (wcount_reg == 16'd0)
                            begin
                                status_next[6] = 1'b1;
                                control_next[7] = 1'b1;
                                control_next[0] = 1'b0;
                                res.irq = control_reg[6];
                            end
                            else if (delay_reg < DELAY_TICKS)
                            begin
                                delay_next = delay_reg + 8'd1;
                            end
                            else
                            begin
                                delay_next = '0;
                                res.xfer_valid = 1'b1;
                                res.xfer_to_disk = (control_reg[3:1] == FN_WRITE);
                                res.xfer_block = block;
                                res.xfer_address = {control_reg[5:4], baddr_reg};
                                res.xfer_words = words;
                                if (!baddr_reg[0] && sum[16])
                                begin
                                    control_next[5:4] = control_reg[5:4] + 2'd1;
                                end
                                baddr_next = sum[15:0];
                                wcount_next = wcount_reg + {7'd0, words};
                                sector_next = sector_inc;
                                if (sector_inc > LAST_SECTOR)
                                begin
                                    sector_next = '0;
                                    surface_next = !surface_reg;
                                    if (surface_reg)
                                    begin
                                        cyl_next = cyl_inc[7:0];
                                    end
                                end
                                if ((sector_inc > LAST_SECTOR) && surface_reg
                                    && (cyl_inc > LAST_CYLINDER))
                                begin
                                    error_next[14] = 1'b1;
                                end
                                else
                                begin
                                    daddr_next = {3'd0, cyl_next, surface_next, sector_next};
                                end
                            end
                        end
                        FN_SEEK, FN_DRIVE_RESET:
                        begin
                            if (control_reg[3:1] == FN_DRIVE_RESET)
                            begin
                                error_next = '0;
                            end
                            status_next[6] = 1'b1;
                            control_next[7] = 1'b1;
                            control_next[0] = 1'b0;
                            if (drive_reg != 3'd0)
                            begin
                                error_next[7] = 1'b1;
                                res.irq = 1'b1;
                            end
                            else
                            begin
                                daddr_next = place;
                                control_next[13] = 1'b1;
                                res.irq = control_reg[6];
                            end
                        end
                        default: ;
                    endcase
                end
            end
            default: ;
        endcase
        count_next = count_reg + {1'b0, cmd_take} - {1'b0, res_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            status_reg <= STATUS_RESET;
            error_reg <= '0;
            control_reg <= CONTROL_RESET;
            wcount_reg <= '0;
            baddr_reg <= '0;
            daddr_reg <= '0;
            drive_reg <= '0;
            cyl_reg <= '0;
            surface_reg <= 1'b0;
            sector_reg <= '0;
            delay_reg <= '0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            if (cmd_take)
            begin
                status_reg <= status_next;
                error_reg <= error_next;
                control_reg <= control_next;
                wcount_reg <= wcount_next;
                baddr_reg <= baddr_next;
                daddr_reg <= daddr_next;
                drive_reg <= drive_next;
                cyl_reg <= cyl_next;
                surface_reg <= surface_next;
                sector_reg <= sector_next;
                delay_reg <= delay_next;
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (res_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_take)
        begin
            entry_reg[wr_ptr_reg] <= res;
        end
    end

endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;

    import cdc_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 300;
    localparam int MAX_REPORTS = 10;
    localparam logic [15:0] CSR_GO = 16'h0001;
    localparam logic [15:0] CSR_IE = 16'h0040;

    class disk_scoreboard;
        logic [15:0] drive_status;
        logic [15:0] error_bits;
        logic [15:0] csr;
        logic [15:0] word_count;
        logic [15:0] bus_addr;
        logic [15:0] disk_addr;
        logic [2:0] drive;
        logic [7:0] cylinder;
        logic surface;
        logic [3:0] sector;
        logic [7:0] delay;
        result_t pending_results[$];
        int mismatches;
        int transactions;
        int transfers;
        int interrupts;
        int bus_errors;

        function new();
            power_on();
            mismatches = 0;
            transactions = 0;
            transfers = 0;
            interrupts = 0;
            bus_errors = 0;
        endfunction

        function void power_on();
            drive_status = STATUS_RESET;
            error_bits = '0;
            csr = CONTROL_RESET;
            word_count = '0;
            bus_addr = '0;
            disk_addr = '0;
            drive = '0;
            cylinder = '0;
            surface = 1'b0;
            sector = '0;
            delay = '0;
        endfunction

        function void make_ready();
            drive_status[6] = 1'b1;
            csr[7] = 1'b1;
            csr[0] = 1'b0;
        endfunction

        function void make_busy();
            drive_status[6] = 1'b0;
            csr[7] = 1'b0;
        endfunction

        function logic [15:0] head_address();
            return {3'b000, cylinder, surface, sector};
        endfunction

        function result_t controller_response(item_t it);
            result_t r;
            logic [2:0] fn;
            logic [15:0] wd;
            int room;
            int count;
            int sum;
            int next_cyl;
            r = '0;
            wd = it.write_data;
            case (it.kind)
                KIND_READ:
                    case (it.register_index)
                        REG_STATUS: r.read_data = drive_status;
                        REG_ERROR: r.read_data = error_bits;
                        REG_CONTROL: r.read_data = csr & 16'hfffe;
                        REG_WORD_COUNT: r.read_data = word_count;
                        REG_BUS_ADDR: r.read_data = bus_addr;
                        REG_DISK_ADDR: r.read_data = disk_addr;
                        default: r.bus_error = 1'b1;
                    endcase
                KIND_WRITE:
                    case (it.register_index)
                        REG_CONTROL:
                            csr = (wd & ~CONTROL_RO_MASK) | (csr & CONTROL_RO_MASK);
                        REG_WORD_COUNT: word_count = wd;
                        REG_BUS_ADDR: bus_addr = wd;
                        REG_DISK_ADDR:
                        begin
                            disk_addr = wd;
                            drive = wd[15:13];
                            cylinder = wd[12:5];
                            surface = wd[4];
                            sector = wd[3:0];
                        end
                        default: ;
                    endcase
                KIND_TICK:
                    if (csr[0])
                    begin
                        csr[13] = 1'b0;
                        fn = csr[3:1];
                        case (fn)
                            FN_CTRL_RESET: power_on();
                            FN_WRITE, FN_READ, FN_READ_CHECK:
                            begin
                                make_busy();
                                disk_addr = head_address();
                                if (word_count == 16'd0)
                                begin
                                    make_ready();
                                    r.irq = csr[6];
                                end
                                else if (delay < DELAY_TICKS)
                                begin
                                    delay = delay + 8'd1;
                                end
                                else
                                begin
                                    delay = '0;
                                    room = 65536 - int'(word_count);
                                    count = (room < int'(WORDS_PER_SECTOR)) ?
                                        room : int'(WORDS_PER_SECTOR);
                                    r.xfer_valid = 1'b1;
                                    r.xfer_to_disk = (fn == FN_WRITE);
                                    r.xfer_block = 13'(int'(cylinder) * 24 +
                                        int'(surface) * 12 + int'(sector));
                                    r.xfer_address = {csr[5:4], bus_addr};
                                    r.xfer_words = 9'(count);
                                    sum = int'(bus_addr) + 2 * count;
                                    if (!bus_addr[0] && sum > 65535)
                                        csr[5:4] = csr[5:4] + 2'd1;
                                    bus_addr = 16'(sum);
                                    word_count = 16'(int'(word_count) + count);
                                    sector = sector + 4'd1;
                                    if (sector > LAST_SECTOR)
                                    begin
                                        sector = '0;
                                        if (surface)
                                        begin
                                            surface = 1'b0;
                                            next_cyl = int'(cylinder) + 1;
                                            cylinder = 8'(next_cyl);
                                            if (next_cyl > int'(LAST_CYLINDER))
                                                error_bits[14] = 1'b1;
                                            else
                                                disk_addr = head_address();
                                        end
                                        else
                                        begin
                                            surface = 1'b1;
                                            disk_addr = head_address();
                                        end
                                    end
                                    else
                                    begin
                                        disk_addr = head_address();
                                    end
                                end
                            end
                            FN_SEEK, FN_DRIVE_RESET:
                            begin
                                if (fn == FN_DRIVE_RESET)
                                    error_bits = '0;
                                make_busy();
                                if (drive != 3'd0)
                                begin
                                    error_bits[7] = 1'b1;
                                    make_ready();
                                    r.irq = 1'b1;
                                end
                                else
                                begin
                                    disk_addr = head_address();
                                    csr[13] = 1'b1;
                                    make_ready();
                                    r.irq = csr[6];
                                end
                            end
                            default: ;
                        endcase
                    end
                default: ;
            endcase
            return r;
        endfunction

        function string show(result_t r);
            return $sformatf("rd=%h berr=%b irq=%b xv=%b tod=%b blk=%0d adr=%h words=%0d",
                r.read_data, r.bus_error, r.irq, r.xfer_valid, r.xfer_to_disk,
                r.xfer_block, r.xfer_address, r.xfer_words);
        endfunction

        function void note_failure(string msg);
            if (mismatches < MAX_REPORTS)
                $display("%0t: %s", $time, msg);
            mismatches++;
        endfunction

        function void note_transaction(item_t it);
            result_t r;
            r = controller_response(it);
            pending_results.push_back(r);
            transactions++;
            if (r.xfer_valid)
                transfers++;
            if (r.irq)
                interrupts++;
            if (r.bus_error)
                bus_errors++;
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (pending_results.size() == 0)
            begin
                note_failure({"unexpected result: ", show(got)});
                return;
            end
            want = pending_results.pop_front();
            if (got.read_data !== want.read_data || got.bus_error !== want.bus_error ||
                got.irq !== want.irq || got.xfer_valid !== want.xfer_valid ||
                got.xfer_to_disk !== want.xfer_to_disk ||
                got.xfer_block !== want.xfer_block ||
                got.xfer_address !== want.xfer_address ||
                got.xfer_words !== want.xfer_words)
                note_failure({"result mismatch: expected ", show(want),
                    " got ", show(got)});
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic push = 1'b0;
    logic full;
    item_t req = '0;
    logic empty;
    logic pop = 1'b0;
    result_t resp;

    disk_scoreboard sb;
    int send_idle_pct = 18;
    int recv_idle_pct = 81;
    int items_sent = 0;
    bit hold_request = 1'b0;
    int cycle_count = 0;

    cartridge_disk_controller_unit u_top (
        .clk(clk),
        .rst_n(rst_n),
        .push(push),
        .full(full),
        .item(req),
        .empty(empty),
        .pop(pop),
        .result(resp)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("cartridge_disk_controller_unit regression: fail");
        $finish;
    end

    initial
    begin
        int hold_left;
        hold_left = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (pop && !empty)
                sb.check_result(resp);
            if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                pop <= 1'b0;
            end
            else
            begin
                pop <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    function automatic logic [15:0] csr_cmd(logic [2:0] fn, bit ie);
        return (ie ? CSR_IE : 16'h0000) | {12'h000, fn, 1'b0} | CSR_GO;
    endfunction

    task automatic send_item(logic [1:0] k, logic [2:0] idx, logic [15:0] d);
        item_t it;
        it.kind = k;
        it.register_index = idx;
        it.write_data = d;
        if ($urandom_range(99) < send_idle_pct)
        begin
            push <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        push <= 1'b1;
        req <= it;
        @(posedge clk);
        while (full)
            @(posedge clk);
        sb.note_transaction(it);
        if (k != OP_IGNORE)
            items_sent++;
    endtask

    task automatic wait_for_drain();
        push <= 1'b0;
        while (sb.pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic run_ticks(int n);
        repeat (n)
        begin
            if ($urandom_range(9) == 0)
                send_item(KIND_READ, 3'($urandom_range(7)), 16'($urandom));
            if ($urandom_range(49) == 0)
                send_item(KIND_WRITE, 3'($urandom_range(7)), 16'($urandom));
            send_item(KIND_TICK, 3'($urandom_range(7)), 16'($urandom));
        end
    endtask

    task automatic run_transfer();
        int words;
        int nticks;
        int pick;
        logic [15:0] ba;
        logic [15:0] da;
        logic [15:0] csr;
        pick = $urandom_range(9);
        if (pick < 6)
            words = $urandom_range(256, 1);
        else if (pick < 9)
            words = $urandom_range(700, 257);
        else
            words = 1;
        pick = $urandom_range(9);
        if (pick < 3)
            ba = 16'($urandom_range(16'hffff, 16'hfc00));
        else if (pick < 8)
            ba = 16'($urandom);
        else
            ba = 16'($urandom_range(15));
        da = 16'($urandom);
        if ($urandom_range(9) != 0)
            da[15:13] = 3'd0;
        if ($urandom_range(9) < 4)
            da[12:5] = 8'($urandom_range(255, 200));
        if ($urandom_range(4) == 0)
        begin
            da[4] = 1'b1;
            da[3:0] = LAST_SECTOR;
        end
        else if ($urandom_range(4) != 0)
        begin
            da[3:0] = 4'($urandom_range(11));
        end
        csr = 16'($urandom);
        pick = $urandom_range(2);
        csr[3:1] = (pick == 0) ? FN_WRITE : (pick == 1) ? FN_READ : FN_READ_CHECK;
        csr[0] = 1'b1;
        send_item(KIND_WRITE, REG_WORD_COUNT, 16'(65536 - words));
        send_item(KIND_WRITE, REG_BUS_ADDR, ba);
        send_item(KIND_WRITE, REG_DISK_ADDR, da);
        send_item(KIND_WRITE, REG_CONTROL, csr);
        nticks = ((words + 255) / 256) * (int'(DELAY_TICKS) + 1) + $urandom_range(3, 1);
        if ($urandom_range(7) == 0)
            nticks = $urandom_range(nticks, 1);
        run_ticks(nticks);
        send_item(KIND_READ, REG_CONTROL, 16'($urandom));
        send_item(KIND_READ, REG_ERROR, 16'($urandom));
    endtask

    task automatic run_seek();
        logic [15:0] da;
        logic [15:0] csr;
        da = 16'($urandom);
        if ($urandom_range(9) < 7)
            da[15:13] = 3'd0;
        csr = 16'($urandom);
        csr[3:1] = $urandom_range(1) ? FN_SEEK : FN_DRIVE_RESET;
        csr[0] = 1'b1;
        send_item(KIND_WRITE, REG_DISK_ADDR, da);
        send_item(KIND_WRITE, REG_CONTROL, csr);
        run_ticks($urandom_range(3, 1));
        send_item(KIND_READ, REG_ERROR, 16'($urandom));
        send_item(KIND_READ, REG_STATUS, 16'($urandom));
    endtask

    task automatic run_phase(int target);
        int pick;
        logic [15:0] csr;
        while (items_sent < target)
        begin
            pick = $urandom_range(99);
            if (pick < 55)
            begin
                run_transfer();
            end
            else if (pick < 72)
            begin
                run_seek();
            end
            else if (pick < 77)
            begin
                csr = 16'($urandom);
                csr[3:1] = FN_CTRL_RESET;
                csr[0] = 1'b1;
                send_item(KIND_WRITE, REG_CONTROL, csr);
                send_item(KIND_TICK, 3'($urandom_range(7)), 16'($urandom));
                send_item(KIND_READ, 3'($urandom_range(7)), 16'($urandom));
            end
            else
            begin
                repeat ($urandom_range(6, 1))
                    send_item(($urandom_range(19) == 0) ? OP_IGNORE :
                        2'($urandom_range(2)), 3'($urandom_range(7)), 16'($urandom));
            end
        end
    endtask

    initial
    begin
        sb = new();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_item(KIND_READ, REG_STATUS, 16'hffff);
        send_item(KIND_READ, REG_ERROR, 16'h0000);
        send_item(KIND_READ, REG_CONTROL, 16'($urandom));
        send_item(KIND_READ, 3'd6, 16'($urandom));
        send_item(KIND_READ, 3'd7, 16'($urandom));
        send_item(OP_IGNORE, REG_CONTROL, 16'hffff);
        send_item(KIND_TICK, REG_STATUS, 16'($urandom));
        send_item(KIND_WRITE, REG_ERROR, 16'hffff);
        send_item(KIND_WRITE, 3'd6, 16'hffff);
        send_item(KIND_WRITE, REG_CONTROL, 16'hffff);
        send_item(KIND_TICK, REG_CONTROL, 16'($urandom));
        send_item(KIND_WRITE, REG_DISK_ADDR, 16'hffff);
        send_item(KIND_WRITE, REG_CONTROL, csr_cmd(FN_SEEK, 1'b1));
        send_item(KIND_TICK, REG_DISK_ADDR, 16'($urandom));
        send_item(KIND_READ, REG_ERROR, 16'($urandom));
        send_item(KIND_WRITE, REG_DISK_ADDR, 16'h0000);
        send_item(KIND_WRITE, REG_CONTROL, csr_cmd(FN_DRIVE_RESET, 1'b0));
        send_item(KIND_TICK, REG_WORD_COUNT, 16'($urandom));
        send_item(KIND_WRITE, REG_CONTROL, csr_cmd(FN_SEEK, 1'b1));
        send_item(KIND_TICK, 3'd7, 16'($urandom));
        send_item(KIND_WRITE, REG_WORD_COUNT, 16'h0000);
        send_item(KIND_WRITE, REG_CONTROL, csr_cmd(FN_READ, 1'b1));
        send_item(KIND_TICK, REG_BUS_ADDR, 16'($urandom));
        send_item(KIND_WRITE, REG_CONTROL, csr_cmd(FN_CTRL_RESET, 1'b0));
        send_item(KIND_TICK, 3'd6, 16'($urandom));
        send_item(KIND_READ, REG_CONTROL, 16'($urandom));
        wait_for_drain();

        run_phase(items_sent + 630);
        send_idle_pct = 81;
        recv_idle_pct = 18;
        run_phase(items_sent + 630);
        wait_for_drain();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_request = 1'b1;
        run_phase(items_sent + 640);
        push <= 1'b0;

        while (sb.pending_results.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        $display("Checked %0d transactions: %0d sector transfers, %0d interrupts, %0d bus errors.",
            sb.transactions, sb.transfers, sb.interrupts, sb.bus_errors);
        $display("Mismatches: %0d over %0d cycles.", sb.mismatches, cycle_count);
        if (sb.mismatches == 0)
            $display("cartridge_disk_controller_unit regression: pass");
        else
            $display("cartridge_disk_controller_unit regression: fail");
        $finish;
    end

endmodule
